[rtl/mpfb_pkg.sv]
// Shared types and constants for the page-organized monochrome display store.
package mpfb_pkg;

  // Default geometry: 128 columns by 8 pages of 8 rows.
  localparam int unsigned ColumnsDef = 128;
  localparam int unsigned PagesDef   = 8;

  // Command codes on the command input.
  typedef enum logic [1:0] {
    CMD_PLOT  = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;         // capture the fields of an accepted command
    logic mem_rd;       // read the store byte addressed by the cursor or the read address
    logic rd_sel;       // address the store with the read command's page and column
    logic mem_wr;       // write back the modified byte of a read-modify-write
    logic advance;      // step the draw cursor to the next byte
    logic sweep_start;  // restart the clearing sweep at address zero
    logic sweep_wr;     // write zero at the sweep address and step it
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic draw_ok;      // a plot or fill on the inputs touches at least one pixel
    logic walk_last;    // the draw cursor sits on the last byte of the rectangle
    logic sweep_last;   // the sweep address is the last store entry
  } dp_stat_t;

endpackage

[rtl/mono_page_framebuffer_plot_fill_top.sv]
// Top level of the page-organized monochrome display store.
//
// The store holds PAGES pages of COLUMNS bytes; row y lives in page PAGES-1-y/8 at bit
// 7-(y mod 8). A command is transferred when start is high and busy is low. Plot does a
// memory read, then a write-back, before it is ready again; fill does one read-modify-write
// for each column byte the clipped rectangle touches, in turn; read reads the store, then
// presents its result with done_o high for exactly one cycle, and the receiver cannot stall
// it. Clear and reset both run a sweep over all PAGES*COLUMNS store bytes (1024 by default)
// writing zero, with busy high throughout.
// A plot or fill that touches no pixel in range is dropped in the transfer cycle.
module mono_page_framebuffer_plot_fill_top #(
  parameter int unsigned COLUMNS = mpfb_pkg::ColumnsDef,
  parameter int unsigned PAGES   = mpfb_pkg::PagesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mpfb_pkg::cmd_e command_i,
  input  logic [6:0]     x_start_i,
  input  logic [5:0]     y_start_i,
  input  logic [6:0]     x_end_i,
  input  logic [5:0]     y_end_i,
  input  logic           pixel_value_i,
  input  logic [2:0]     read_page_i,
  output logic           done_o,
  output logic [7:0]     read_data_o,
  output logic [2:0]     read_page_out_o,
  output logic [6:0]     read_column_out_o
);
  import mpfb_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Command sequencing.
  mpfb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .busy      (busy),
    .done_o    (done_o)
  );

  // Store and addressing.
  mpfb_dp #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .command_i         (command_i),
    .x_start_i         (x_start_i),
    .y_start_i         (y_start_i),
    .x_end_i           (x_end_i),
    .y_end_i           (y_end_i),
    .pixel_value_i     (pixel_value_i),
    .read_page_i       (read_page_i),
    .cmd_i             (dp_cmd),
    .stat_o            (dp_stat),
    .read_data_o       (read_data_o),
    .read_page_out_o   (read_page_out_o),
    .read_column_out_o (read_column_out_o)
  );

endmodule

[rtl/mpfb_dp.sv]
// Datapath: display store, draw cursor, byte mask and clearing sweep counter.
module mpfb_dp #(
  parameter int unsigned COLUMNS = mpfb_pkg::ColumnsDef,
  parameter int unsigned PAGES   = mpfb_pkg::PagesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpfb_pkg::cmd_e      command_i,
  input  logic [6:0]          x_start_i,
  input  logic [5:0]          y_start_i,
  input  logic [6:0]          x_end_i,
  input  logic [5:0]          y_end_i,
  input  logic                pixel_value_i,
  input  logic [2:0]          read_page_i,
  input  mpfb_pkg::dp_cmd_t   cmd_i,
  output mpfb_pkg::dp_stat_t  stat_o,
  output logic [7:0]          read_data_o,
  output logic [2:0]          read_page_out_o,
  output logic [6:0]          read_column_out_o
);
  import mpfb_pkg::*;

  localparam int unsigned Depth = PAGES * COLUMNS;
  localparam int unsigned Rows  = PAGES * 8;
  localparam int unsigned AddrW = $clog2(Depth);

  localparam logic [8:0]       ColsL   = 9'(COLUMNS);
  localparam logic [8:0]       RowsL   = 9'(Rows);
  localparam logic [4:0]       PagesL  = 5'(PAGES);
  localparam logic [AddrW-1:0] PageTop = AddrW'(PAGES - 1);
  localparam logic [AddrW-1:0] ColsA   = AddrW'(COLUMNS);
  localparam logic [AddrW-1:0] LastA   = AddrW'(Depth - 1);

  // Store and its registered read port.
  logic [7:0]       store_q [Depth];
  logic [7:0]       rd_data_q;

  // Captured command fields and draw cursor.
  logic [6:0]       x_q;      // cursor column, also the read column
  logic [6:0]       xe_q;     // last column of the walk
  logic [2:0]       g_q;      // cursor row group (row / 8)
  logic [2:0]       gs_q;     // first row group
  logic [2:0]       ge_q;     // last row group
  logic [2:0]       ylo_q;    // row offset of the first row in its group
  logic [2:0]       yhi_q;    // row offset of the last row in its group
  logic             val_q;
  logic [2:0]       page_q;
  logic             rd_ok_q;
  logic [AddrW-1:0] sweep_q;

  // Input decode.
  logic       x_in_rng, y_in_rng, fill_ok, read_ok;
  logic [6:0] xe_clamp;
  logic [5:0] ye_clamp;

  always_comb begin
    x_in_rng = ({2'b00, x_start_i} < ColsL);
    y_in_rng = ({3'b000, y_start_i} < RowsL);
    fill_ok  = (x_start_i <= x_end_i) && (y_start_i <= y_end_i);
    read_ok  = ({2'b00, read_page_i} < PagesL) && x_in_rng;
    xe_clamp = ({2'b00, x_end_i} < ColsL) ? x_end_i : 7'(ColsL - 9'd1);
    ye_clamp = ({3'b000, y_end_i} < RowsL) ? y_end_i : 6'(RowsL - 9'd1);
  end

  assign stat_o.draw_ok = x_in_rng && y_in_rng && ((command_i != CMD_FILL) || fill_ok);

  // Bit mask of the rows of the current group that lie inside the rectangle.
  // Row offset k within a group lands on bit 7-k.
  logic [2:0] lo_off, hi_off;
  logic [7:0] mask;

  always_comb begin
    lo_off = (g_q == gs_q) ? ylo_q : 3'd0;
    hi_off = (g_q == ge_q) ? yhi_q : 3'd7;
    mask   = (8'hFF >> lo_off) & (8'hFF << (3'd7 - hi_off));
  end

  assign stat_o.walk_last  = (g_q == ge_q) && (x_q == xe_q);
  assign stat_o.sweep_last = (sweep_q == LastA);

  // Store addressing: pages run upward from the bottom row group.
  logic [AddrW-1:0] page_base, walk_addr, read_addr, rd_addr, wr_addr;
  logic [7:0]       wr_data;
  logic             wr_en;

  always_comb begin
    page_base = PageTop - AddrW'(g_q);
    walk_addr = page_base * ColsA + AddrW'(x_q);
    read_addr = AddrW'(page_q) * ColsA + AddrW'(x_q);
    rd_addr   = cmd_i.rd_sel ? read_addr : walk_addr;
    wr_en     = cmd_i.mem_wr || cmd_i.sweep_wr;
    wr_addr   = cmd_i.sweep_wr ? sweep_q : walk_addr;
    if (cmd_i.sweep_wr) begin
      wr_data = 8'h00;
    end else if (val_q) begin
      wr_data = rd_data_q | mask;
    end else begin
      wr_data = rd_data_q & ~mask;
    end
  end

  // Store access and captured payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd && (cmd_i.rd_sel ? rd_ok_q : 1'b1)) begin
      rd_data_q <= store_q[rd_addr];
    end
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    if (cmd_i.load) begin
      x_q     <= x_start_i;
      g_q     <= y_start_i[5:3];
      gs_q    <= y_start_i[5:3];
      ylo_q   <= y_start_i[2:0];
      val_q   <= pixel_value_i;
      page_q  <= read_page_i;
      rd_ok_q <= read_ok;
      if (command_i == CMD_FILL) begin
        xe_q  <= xe_clamp;
        ge_q  <= ye_clamp[5:3];
        yhi_q <= ye_clamp[2:0];
      end else begin
        xe_q  <= x_start_i;
        ge_q  <= y_start_i[5:3];
        yhi_q <= y_start_i[2:0];
      end
    end else if (cmd_i.advance) begin
      // Walk the row groups of one column, then move to the next column.
      if (g_q == ge_q) begin
        g_q <= gs_q;
        x_q <= x_q + 7'd1;
      end else begin
        g_q <= g_q + 3'd1;
      end
    end
  end

  // Clearing sweep address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_start) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_wr) begin
      sweep_q <= sweep_q + AddrW'(1);
    end
  end

  // Read result fields; an out-of-range read returns zero data.
  assign read_data_o       = rd_ok_q ? rd_data_q : 8'h00;
  assign read_page_out_o   = page_q;
  assign read_column_out_o = x_q;

endmodule

[rtl/mpfb_ctrl.sv]
// Controller: command sequencing for draw, read and clear operations.
module mpfb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  mpfb_pkg::cmd_e      command_i,
  input  mpfb_pkg::dp_stat_t  stat_i,
  output mpfb_pkg::dp_cmd_t   cmd_o,
  output logic                busy,
  output logic                done_o
);
  import mpfb_pkg::*;

  typedef enum logic [5:0] {
    ST_SWEEP    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_RMW_RD   = 6'b000100,
    ST_RMW_WR   = 6'b001000,
    ST_READ_RD  = 6'b010000,
    ST_READ_OUT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (command_i)
            CMD_PLOT, CMD_FILL: begin
              if (stat_i.draw_ok) begin
                state_d = ST_RMW_RD;
              end
            end
            CMD_READ: state_d = ST_READ_RD;
            CMD_CLEAR: begin
              cmd_o.sweep_start = 1'b1;
              state_d           = ST_SWEEP;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RMW_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.advance = 1'b1;
        state_d       = stat_i.walk_last ? ST_IDLE : ST_RMW_RD;
      end
      ST_READ_RD: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.rd_sel = 1'b1;
        state_d      = ST_READ_OUT;
      end
      ST_READ_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State register; reset starts the clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_READ_OUT);

  // A write-back always follows the read of the same byte.
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_wr |-> $past(cmd_o.mem_rd && !cmd_o.rd_sel))
    else $error("write-back without a preceding store read");

  // An accepted read presents its result on done_o once its store read state has passed.
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CMD_READ) |-> ##2 done_o)
    else $error("read result missing");

  // The block only goes idle at the end of a write-back, a sweep or a result.
  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(cmd_o.mem_wr || cmd_o.sweep_wr || done_o))
    else $error("busy dropped in the middle of an operation");

endmodule
